/* rtl/core/utf8_stream_decoder_fallback_core_assert.svh */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_fallback_core_assert
// Assertion macros shared by the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_FALLBACK_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_FALLBACK_CORE_ASSERT_SVH

// property checked on every clock edge outside reset
`define UTF8D_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define UTF8D_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types, constants and mapping functions of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utf8d_pkg;

   localparam int MAX_SEQ_LEN_DEF = 4;
   localparam int BYTE_W          = 8;
   localparam int CP_W            = 21;
   localparam int LEN_W           = 3;
   localparam int ONES_W          = 4;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLAY,
      ST_FINAL
   } state_type;

   // source of the next result
   typedef enum logic [2:0] {
      SRC_FALLBACK_IN,
      SRC_PARTIAL,
      SRC_END,
      SRC_PENDING,
      SRC_FALLBACK_HOLD
   } out_src_type;

   // sequence state update
   typedef enum logic [2:0] {
      SEQ_HOLD,
      SEQ_START_IN,
      SEQ_START_HOLD,
      SEQ_APPEND,
      SEQ_CLEAR
   } seq_op_type;

   typedef struct packed {
      logic        out_load;
      out_src_type out_src;
      logic        out_last;
      seq_op_type  seq_op;
      logic        hold_load;
      logic        idx_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_end;
      logic seq_pending;
      logic is_cont;
      logic cont_completes;
      logic in_lead_ok;
      logic hold_lead_ok;
      logic replay_last;
   } dp_status_type;

   // windows-1252 mapping, latin-1 for everything not defined
   function automatic logic [CP_W-1:0] w1252_map(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] cp;
      unique case (b)
         8'h80:   cp = 21'h020AC;
         8'h82:   cp = 21'h0201A;
         8'h83:   cp = 21'h00192;
         8'h84:   cp = 21'h0201E;
         8'h85:   cp = 21'h02026;
         8'h86:   cp = 21'h02020;
         8'h87:   cp = 21'h02021;
         8'h88:   cp = 21'h002C6;
         8'h89:   cp = 21'h02030;
         8'h8A:   cp = 21'h00160;
         8'h8B:   cp = 21'h02039;
         8'h8C:   cp = 21'h00152;
         8'h8E:   cp = 21'h0017D;
         8'h91:   cp = 21'h02018;
         8'h92:   cp = 21'h02019;
         8'h93:   cp = 21'h0201C;
         8'h94:   cp = 21'h0201D;
         8'h95:   cp = 21'h02022;
         8'h96:   cp = 21'h02013;
         8'h97:   cp = 21'h02014;
         8'h98:   cp = 21'h002DC;
         8'h99:   cp = 21'h02122;
         8'h9A:   cp = 21'h00161;
         8'h9B:   cp = 21'h0203A;
         8'h9C:   cp = 21'h00153;
         8'h9E:   cp = 21'h0017E;
         8'h9F:   cp = 21'h00178;
         default: cp = CP_W'(b);
      endcase
      return cp;
   endfunction

   // number of leading one bits of a byte
   function automatic logic [ONES_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
      logic [ONES_W-1:0] n;
      logic              done;
      n    = '0;
      done = 1'b0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (!done && b[i]) begin
            n = n + 1'b1;
         end else begin
            done = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

/* rtl/core/utf8d_intf.sv */
// ----------------------------------------------------------------------------
// utf8d_intf
// Valid/ready channels for the byte input and the code point output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface utf8d_req_intf;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [utf8d_pkg::BYTE_W-1:0]    byte_value;

   modport source (output valid, output command, output byte_value, input ready);
   modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface utf8d_rsp_intf;
   logic                            valid;
   logic                            ready;
   logic [utf8d_pkg::CP_W-1:0]      code_point;
   logic                            end_marker;
   logic                            last_of_run;

   modport source (output valid, output code_point, output end_marker,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input end_marker,
                   input last_of_run, output ready);
endinterface

/* rtl/core/utf8_stream_decoder_fallback_core.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder_fallback_core
// UTF-8 byte stream decoder with Windows-1252 fallback for broken input.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    command, byte_value
//   rsp_ch    out   valid / ready    code_point, end_marker, last_of_run
//
// A byte that causes no result or one result is handled in the cycle it is accepted.
// An end command or a broken sequence with k >= 1 buffered bytes gives k+1 results, or k
// when the breaking byte starts a new sequence; one result per cycle while the output has room.
// Input is taken only by the controller's idle state with room in that register.
// Synchronous active-high reset clears the sequence state and the output valid.
// A stalled output holds its result; replay waits for the register to drain.
`timescale 1ns / 1ps

module utf8_stream_decoder_fallback_core #(
   parameter int MAX_SEQ_LEN = utf8d_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic         clock,
   input  logic         reset,
   utf8d_req_intf.sink  req_ch,
   utf8d_rsp_intf.source rsp_ch
);

   utf8d_pkg::dp_cmd_type    cmd;
   utf8d_pkg::dp_status_type status;

   // control
   utf8d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   utf8d_dpath #(
      .MAX_SEQ_LEN (MAX_SEQ_LEN)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_ch.command),
      .req_byte        (req_ch.byte_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_code_point  (rsp_ch.code_point),
      .rsp_end_marker  (rsp_ch.end_marker),
      .rsp_last_of_run (rsp_ch.last_of_run)
   );

endmodule

/* rtl/core/utf8d_dpath.sv */
// ----------------------------------------------------------------------------
// utf8d_dpath
// Sequence buffer, code point accumulator and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_stream_decoder_fallback_core_assert.svh"

module utf8d_dpath #(
   parameter int MAX_SEQ_LEN = utf8d_pkg::MAX_SEQ_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_command,
   input  logic [utf8d_pkg::BYTE_W-1:0]   req_byte,
   input  utf8d_pkg::dp_cmd_type          cmd,
   output utf8d_pkg::dp_status_type       status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [utf8d_pkg::CP_W-1:0]     rsp_code_point,
   output logic                           rsp_end_marker,
   output logic                           rsp_last_of_run
);

   localparam int PEND_DEPTH = MAX_SEQ_LEN - 1;
   localparam int IDX_W      = $clog2(PEND_DEPTH);
   localparam int BW         = utf8d_pkg::BYTE_W;
   localparam int CW         = utf8d_pkg::CP_W;
   localparam int LW         = utf8d_pkg::LEN_W;
   localparam int OW         = utf8d_pkg::ONES_W;
   localparam logic [OW-1:0] MAX_LEN    = OW'(MAX_SEQ_LEN);
   localparam logic [LW-1:0] PEND_LIMIT = LW'(PEND_DEPTH);

   logic [BW-1:0]    pend_ff [PEND_DEPTH];
   logic [LW-1:0]    need_ff, need_in;
   logic [LW-1:0]    rc_ff, rc_in;
   logic [CW-1:0]    partial_ff, partial_in;
   logic [BW-1:0]    hold_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [CW-1:0]    out_code_ff, out_code_in;
   logic             out_end_ff;
   logic             out_last_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [BW-1:0]    wr_data;
   logic [OW-1:0]    in_ones, hold_ones;
   logic [CW-1:0]    appended;

   // byte classification
   assign in_ones   = utf8d_pkg::lead_ones(req_byte);
   assign hold_ones = utf8d_pkg::lead_ones(hold_ff);
   assign appended  = {partial_ff[CW-7:0], req_byte[5:0]};

   // status toward the controller
   always_comb begin
      status.out_free       = !out_valid_ff || rsp_ready;
      status.is_end         = req_command;
      status.seq_pending    = (need_ff != '0);
      status.is_cont        = (req_byte[7:6] == 2'b10);
      status.cont_completes = ({1'b0, rc_ff} + 4'd1) >= {1'b0, need_ff};
      status.in_lead_ok     = (in_ones >= OW'(2)) && (in_ones <= MAX_LEN);
      status.hold_lead_ok   = (hold_ones >= OW'(2)) && (hold_ones <= MAX_LEN);
      status.replay_last    = (LW'(idx_ff) == (rc_ff - 3'd1));
   end

   // sequence state update
   always_comb begin
      need_in    = need_ff;
      rc_in      = rc_ff;
      partial_in = partial_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = req_byte;
      unique case (cmd.seq_op)
         utf8d_pkg::SEQ_HOLD: begin
         end
         utf8d_pkg::SEQ_START_IN: begin
            need_in    = in_ones[LW-1:0];
            rc_in      = 3'd1;
            partial_in = CW'(req_byte & (8'hFF >> in_ones));
            wr_en      = 1'b1;
         end
         utf8d_pkg::SEQ_START_HOLD: begin
            need_in    = hold_ones[LW-1:0];
            rc_in      = 3'd1;
            partial_in = CW'(hold_ff & (8'hFF >> hold_ones));
            wr_en      = 1'b1;
            wr_data    = hold_ff;
         end
         utf8d_pkg::SEQ_APPEND: begin
            partial_in = appended;
            rc_in      = rc_ff + 3'd1;
            wr_en      = (rc_ff < PEND_LIMIT);
            wr_addr    = rc_ff[IDX_W-1:0];
         end
         utf8d_pkg::SEQ_CLEAR: begin
            need_in    = '0;
            rc_in      = '0;
            partial_in = '0;
         end
         default: begin
         end
      endcase
   end

   // replay index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.hold_load) begin
         idx_in = '0;
      end else if (cmd.idx_inc && !status.replay_last) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // result selection
   always_comb begin
      unique case (cmd.out_src)
         utf8d_pkg::SRC_FALLBACK_IN:   out_code_in = utf8d_pkg::w1252_map(req_byte);
         utf8d_pkg::SRC_PARTIAL:       out_code_in = appended;
         utf8d_pkg::SRC_END:           out_code_in = '0;
         utf8d_pkg::SRC_PENDING:       out_code_in = utf8d_pkg::w1252_map(pend_ff[idx_ff]);
         utf8d_pkg::SRC_FALLBACK_HOLD: out_code_in = utf8d_pkg::w1252_map(hold_ff);
         default:                      out_code_in = '0;
      endcase
   end

   // output register occupancy
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         need_ff      <= '0;
         rc_ff        <= '0;
         partial_ff   <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         need_ff      <= need_in;
         rc_ff        <= rc_in;
         partial_ff   <= partial_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pend_ff[wr_addr] <= wr_data;
      end
      if (cmd.hold_load) begin
         hold_ff <= req_byte;
      end
      if (cmd.out_load) begin
         out_code_ff <= out_code_in;
         out_end_ff  <= (cmd.out_src == utf8d_pkg::SRC_END);
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_code_point  = out_code_ff;
   assign rsp_end_marker  = out_end_ff;
   assign rsp_last_of_run = out_last_ff;

   // checks
   `UTF8D_ASSERT_RST(a_count_below_len, clock, reset,
      (need_ff == '0 || rc_ff < need_ff), "buffered count reached sequence length")
   `UTF8D_ASSERT_RST(a_count_matches_len, clock, reset,
      ((need_ff == '0) == (rc_ff == '0)), "buffered count and length disagree")
   `UTF8D_ASSERT_RST(a_end_is_last, clock, reset,
      (out_valid_ff && out_end_ff |-> out_last_ff && out_code_ff == '0),
      "end marker not last or not zero")

endmodule

/* rtl/core/utf8d_ctrl.sv */
// ----------------------------------------------------------------------------
// utf8d_ctrl
// Controller: classifies each transaction and sequences fallback replay.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "utf8_stream_decoder_fallback_core_assert.svh"

module utf8d_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  utf8d_pkg::dp_status_type   status,
   output utf8d_pkg::dp_cmd_type      cmd
);

   utf8d_pkg::state_type state_ff, state_in;
   logic                 end_kind_ff, end_kind_in;
   logic                 take;

   assign req_ready = (state_ff == utf8d_pkg::ST_IDLE) && status.out_free;
   assign take      = req_valid && req_ready;

   // next state
   always_comb begin
      state_in    = state_ff;
      end_kind_in = end_kind_ff;
      unique case (state_ff)
         utf8d_pkg::ST_IDLE: begin
            if (take && status.seq_pending &&
                (status.is_end || !status.is_cont)) begin
               state_in    = utf8d_pkg::ST_REPLAY;
               end_kind_in = status.is_end;
            end
         end
         utf8d_pkg::ST_REPLAY: begin
            if (status.out_free && status.replay_last) begin
               if (!end_kind_ff && status.hold_lead_ok) begin
                  state_in = utf8d_pkg::ST_IDLE;
               end else begin
                  state_in = utf8d_pkg::ST_FINAL;
               end
            end
         end
         utf8d_pkg::ST_FINAL: begin
            if (status.out_free) begin
               state_in = utf8d_pkg::ST_IDLE;
            end
         end
         default: state_in = utf8d_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.out_load  = 1'b0;
      cmd.out_src   = utf8d_pkg::SRC_FALLBACK_IN;
      cmd.out_last  = 1'b0;
      cmd.seq_op    = utf8d_pkg::SEQ_HOLD;
      cmd.hold_load = 1'b0;
      cmd.idx_inc   = 1'b0;
      unique case (state_ff)
         utf8d_pkg::ST_IDLE: begin
            if (take) begin
               priority if (status.is_end && !status.seq_pending) begin
                  cmd.out_load = 1'b1;
                  cmd.out_src  = utf8d_pkg::SRC_END;
                  cmd.out_last = 1'b1;
                  cmd.seq_op   = utf8d_pkg::SEQ_CLEAR;
               end else if (status.is_end) begin
                  cmd.hold_load = 1'b1;
               end else if (!status.seq_pending) begin
                  if (status.in_lead_ok) begin
                     cmd.seq_op = utf8d_pkg::SEQ_START_IN;
                  end else begin
                     cmd.out_load = 1'b1;
                     cmd.out_src  = utf8d_pkg::SRC_FALLBACK_IN;
                     cmd.out_last = 1'b1;
                  end
               end else if (status.is_cont) begin
                  if (status.cont_completes) begin
                     cmd.out_load = 1'b1;
                     cmd.out_src  = utf8d_pkg::SRC_PARTIAL;
                     cmd.out_last = 1'b1;
                     cmd.seq_op   = utf8d_pkg::SEQ_CLEAR;
                  end else begin
                     cmd.seq_op = utf8d_pkg::SEQ_APPEND;
                  end
               end else begin
                  // broken sequence, replay the buffer first
                  cmd.hold_load = 1'b1;
               end
            end
         end
         utf8d_pkg::ST_REPLAY: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = utf8d_pkg::SRC_PENDING;
               cmd.idx_inc  = 1'b1;
               if (status.replay_last) begin
                  // a breaking lead byte starts the next sequence silently
                  if (!end_kind_ff && status.hold_lead_ok) begin
                     cmd.out_last = 1'b1;
                     cmd.seq_op   = utf8d_pkg::SEQ_START_HOLD;
                  end else begin
                     cmd.seq_op = utf8d_pkg::SEQ_CLEAR;
                  end
               end
            end
         end
         utf8d_pkg::ST_FINAL: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               cmd.out_src  = end_kind_ff ? utf8d_pkg::SRC_END
                                          : utf8d_pkg::SRC_FALLBACK_HOLD;
            end
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= utf8d_pkg::ST_IDLE;
         end_kind_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         end_kind_ff <= end_kind_in;
      end
   end

   // checks
   `UTF8D_ASSERT_RST(a_load_needs_room, clock, reset,
      (cmd.out_load |-> status.out_free), "result loaded into a full output register")
   `UTF8D_ASSERT_RST(a_replay_has_bytes, clock, reset,
      (state_ff == utf8d_pkg::ST_REPLAY |-> status.seq_pending),
      "replay with an empty buffer")
   `UTF8D_ASSERT_RST(a_final_cleared, clock, reset,
      (state_ff == utf8d_pkg::ST_FINAL |-> !status.seq_pending),
      "sequence still pending in final step")

endmodule
